// ===== design/htw_pkg.sv =====
// Shared types and constants for the hierarchical timing wheel.
// Used by htw_ctrl, htw_datapath and hierarchical_timing_wheel_unit.
// No dependencies.
`default_nettype none

package htw_pkg;

    // Pool pointer width; the all-ones code marks an empty link
    localparam int PTR_W = 7;
    localparam logic [PTR_W-1:0] NIL = 7'd127;

    // Result kinds
    localparam logic [2:0] KIND_EXPIRED  = 3'd0;
    localparam logic [2:0] KIND_FIRED    = 3'd1;
    localparam logic [2:0] KIND_ACCEPTED = 3'd2;
    localparam logic [2:0] KIND_REJECTED = 3'd3;
    localparam logic [2:0] KIND_NONE     = 3'd4;

    // Datapath operations issued by the controller
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_CAPTURE    = 4'd1;
    localparam logic [3:0] OP_EMIT_ADD   = 4'd2;
    localparam logic [3:0] OP_ALLOC_RD   = 4'd3;
    localparam logic [3:0] OP_ALLOC_WB   = 4'd4;
    localparam logic [3:0] OP_FILE_RD    = 4'd5;
    localparam logic [3:0] OP_FILE_WB    = 4'd6;
    localparam logic [3:0] OP_BKT_RD     = 4'd7;
    localparam logic [3:0] OP_BKT_CLR    = 4'd8;
    localparam logic [3:0] OP_ENT_RD     = 4'd9;
    localparam logic [3:0] OP_DRAIN_WB   = 4'd10;
    localparam logic [3:0] OP_REFILE_GET = 4'd11;
    localparam logic [3:0] OP_ADVANCE    = 4'd12;
    localparam logic [3:0] OP_FINISH     = 4'd13;
    localparam logic [3:0] OP_CLEAR      = 4'd14;

    typedef struct packed {
        logic               mode;
        logic [31:0]        timer_handle;
        logic signed [31:0] delay_ticks;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] fired_handle;
        logic        last;
    } result_t;

    // One bucket list: head and tail pointers
    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
    } bucket_t;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] kind;
        logic       near_sel;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic fire_now;
        logic pool_empty;
        logic cur_ok;
        logic refile_need;
        logic can_emit;
        logic pend_valid;
        logic clear_done;
    } status_t;

endpackage

`default_nettype wire

// ===== design/htw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/htw_ctrl.sv =====
// Sequencer for the timing wheel: add, drain, advance, cascade and clear.
// Depends on htw_pkg.
`default_nettype none

module htw_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire htw_pkg::status_t status,
    output htw_pkg::cmd_t         cmd
);

    localparam logic [4:0] S_CLEAR     = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_DISPATCH  = 5'd2;
    localparam logic [4:0] S_ADD_EMIT  = 5'd3;
    localparam logic [4:0] S_ALLOC_RD  = 5'd4;
    localparam logic [4:0] S_ALLOC_WB  = 5'd5;
    localparam logic [4:0] S_FILE_RD   = 5'd6;
    localparam logic [4:0] S_FILE_WB   = 5'd7;
    localparam logic [4:0] S_T_BKT_RD  = 5'd8;
    localparam logic [4:0] S_T_BKT_CLR = 5'd9;
    localparam logic [4:0] S_D_LOOP    = 5'd10;
    localparam logic [4:0] S_DRAIN_WB  = 5'd11;
    localparam logic [4:0] S_ADV       = 5'd12;
    localparam logic [4:0] S_REF_CHK   = 5'd13;
    localparam logic [4:0] S_R_BKT_CLR = 5'd14;
    localparam logic [4:0] S_R_LOOP    = 5'd15;
    localparam logic [4:0] S_R_GET     = 5'd16;
    localparam logic [4:0] S_R_FILE_RD = 5'd17;
    localparam logic [4:0] S_R_FILE_WB = 5'd18;
    localparam logic [4:0] S_FINISH    = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic       phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg  <= htw_pkg::KIND_ACCEPTED;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            phase_reg <= phase_next;
        end
    end

    assign item_stall = (state_reg != S_IDLE);

    // Next state and command
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        phase_next   = phase_reg;
        cmd.op       = htw_pkg::OP_NONE;
        cmd.kind     = kind_reg;
        cmd.near_sel = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = htw_pkg::OP_CLEAR;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = htw_pkg::OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.mode)
                begin
                    phase_next = 1'b0;
                    state_next = S_T_BKT_RD;
                end
                else if (status.fire_now)
                begin
                    kind_next  = htw_pkg::KIND_FIRED;
                    state_next = S_ADD_EMIT;
                end
                else if (status.pool_empty)
                begin
                    kind_next  = htw_pkg::KIND_REJECTED;
                    state_next = S_ADD_EMIT;
                end
                else
                begin
                    state_next = S_ALLOC_RD;
                end
            end
            S_ADD_EMIT:
            begin
                if (status.can_emit)
                begin
                    cmd.op     = htw_pkg::OP_EMIT_ADD;
                    state_next = S_IDLE;
                end
            end
            S_ALLOC_RD:
            begin
                cmd.op     = htw_pkg::OP_ALLOC_RD;
                state_next = S_ALLOC_WB;
            end
            S_ALLOC_WB:
            begin
                cmd.op     = htw_pkg::OP_ALLOC_WB;
                state_next = S_FILE_RD;
            end
            S_FILE_RD:
            begin
                cmd.op     = htw_pkg::OP_FILE_RD;
                state_next = S_FILE_WB;
            end
            S_FILE_WB:
            begin
                cmd.op     = htw_pkg::OP_FILE_WB;
                kind_next  = htw_pkg::KIND_ACCEPTED;
                state_next = S_ADD_EMIT;
            end
            // Near bucket drain
            S_T_BKT_RD:
            begin
                cmd.op     = htw_pkg::OP_BKT_RD;
                state_next = S_T_BKT_CLR;
            end
            S_T_BKT_CLR:
            begin
                cmd.op     = htw_pkg::OP_BKT_CLR;
                state_next = S_D_LOOP;
            end
            S_D_LOOP:
            begin
                if (status.cur_ok)
                begin
                    cmd.op     = htw_pkg::OP_ENT_RD;
                    state_next = S_DRAIN_WB;
                end
                else if (!phase_reg)
                begin
                    state_next = S_ADV;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DRAIN_WB:
            begin
                if (!status.pend_valid || status.can_emit)
                begin
                    cmd.op     = htw_pkg::OP_DRAIN_WB;
                    state_next = S_D_LOOP;
                end
            end
            S_ADV:
            begin
                cmd.op     = htw_pkg::OP_ADVANCE;
                state_next = S_REF_CHK;
            end
            // Cascade one level bucket
            S_REF_CHK:
            begin
                if (status.refile_need)
                begin
                    cmd.op       = htw_pkg::OP_BKT_RD;
                    cmd.near_sel = 1'b0;
                    state_next   = S_R_BKT_CLR;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_T_BKT_RD;
                end
            end
            S_R_BKT_CLR:
            begin
                cmd.op     = htw_pkg::OP_BKT_CLR;
                state_next = S_R_LOOP;
            end
            S_R_LOOP:
            begin
                if (status.cur_ok)
                begin
                    cmd.op     = htw_pkg::OP_ENT_RD;
                    state_next = S_R_GET;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = S_T_BKT_RD;
                end
            end
            S_R_GET:
            begin
                cmd.op     = htw_pkg::OP_REFILE_GET;
                state_next = S_R_FILE_RD;
            end
            S_R_FILE_RD:
            begin
                cmd.op     = htw_pkg::OP_FILE_RD;
                state_next = S_R_FILE_WB;
            end
            S_R_FILE_WB:
            begin
                cmd.op     = htw_pkg::OP_FILE_WB;
                state_next = S_R_LOOP;
            end
            S_FINISH:
            begin
                if (status.can_emit)
                begin
                    cmd.op     = htw_pkg::OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/htw_datapath.sv =====
// Datapath: tick count, free list, bucket and entry memories, output register.
// Depends on htw_pkg and htw_ram.
`default_nettype none

module htw_datapath #(
    parameter int POOL_ENTRIES = 64,
    parameter int NEAR_BITS    = 8,
    parameter int LEVEL_BITS   = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire htw_pkg::cmd_t    cmd,
    output htw_pkg::status_t      status,
    input  wire htw_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output htw_pkg::result_t      result
);

    localparam int PW        = htw_pkg::PTR_W;
    localparam int NEAR_SIZE = 1 << NEAR_BITS;
    localparam int LVL_DEPTH = 4 << LEVEL_BITS;
    localparam int LVL_AW    = LEVEL_BITS + 2;
    localparam int IDX_W     = $clog2(POOL_ENTRIES);
    localparam int STEP_W    = $clog2(POOL_ENTRIES + 1);
    localparam int CLR_A     = (NEAR_SIZE > LVL_DEPTH) ? NEAR_SIZE : LVL_DEPTH;
    localparam int CLR_DEPTH = (CLR_A > POOL_ENTRIES) ? CLR_A : POOL_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
    localparam logic [PW-1:0]     POOL_P = PW'(POOL_ENTRIES);
    localparam logic [STEP_W-1:0] POOL_S = STEP_W'(POOL_ENTRIES);

    localparam htw_pkg::bucket_t EMPTY = '{head: htw_pkg::NIL, tail: htw_pkg::NIL};

    // Registers
    logic [31:0]             tick_reg;
    logic [PW-1:0]           free_head_reg;
    htw_pkg::item_t          item_reg;
    logic [PW-1:0]           e_reg;
    logic [31:0]             exp_reg;
    logic [PW-1:0]           cur_reg;
    logic [PW-1:0]           nxt_reg;
    logic [STEP_W-1:0]       steps_reg;
    logic                    bsel_near_reg;
    logic [NEAR_BITS-1:0]    baddr_near_reg;
    logic [LVL_AW-1:0]       baddr_lvl_reg;
    logic                    pend_valid_reg;
    logic [31:0]             pend_handle_reg;
    logic                    out_valid_reg;
    htw_pkg::result_t        out_reg;
    logic [CLR_W-1:0]        clr_cnt_reg;

    // Memory ports
    logic                    near_we, near_re;
    logic [NEAR_BITS-1:0]    near_waddr, near_raddr;
    htw_pkg::bucket_t        near_wdata, near_rdata;
    logic                    lvl_we, lvl_re;
    logic [LVL_AW-1:0]       lvl_waddr, lvl_raddr;
    htw_pkg::bucket_t        lvl_wdata, lvl_rdata;
    logic                    nl_we, ent_re;
    logic [IDX_W-1:0]        nl_waddr, ent_raddr;
    logic [PW-1:0]           nl_wdata, nl_rdata;
    logic                    ent_we;
    logic [31:0]             exp_rdata, hdl_rdata;
    logic [31:0]             add_expiry;

    htw_ram #(.WIDTH(2 * PW), .DEPTH(NEAR_SIZE)) u_near (
        .clk(clk), .we(near_we), .waddr(near_waddr), .wdata(near_wdata),
        .re(near_re), .raddr(near_raddr), .rdata(near_rdata)
    );
    htw_ram #(.WIDTH(2 * PW), .DEPTH(LVL_DEPTH)) u_lvl (
        .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
        .re(lvl_re), .raddr(lvl_raddr), .rdata(lvl_rdata)
    );
    htw_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_link (
        .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
        .re(ent_re), .raddr(ent_raddr), .rdata(nl_rdata)
    );
    htw_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_expiry (
        .clk(clk), .we(ent_we), .waddr(e_reg[IDX_W-1:0]), .wdata(add_expiry),
        .re(ent_re), .raddr(ent_raddr), .rdata(exp_rdata)
    );
    htw_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_handle (
        .clk(clk), .we(ent_we), .waddr(e_reg[IDX_W-1:0]),
        .wdata(item_reg.timer_handle),
        .re(ent_re), .raddr(ent_raddr), .rdata(hdl_rdata)
    );

    assign add_expiry = tick_reg + 32'(item_reg.delay_ticks);

    // Bucket choice for exp_reg against the current tick
    logic [63:0]           t64, c64;
    logic                  f_near;
    logic [2:0]            lv_match;
    logic [1:0]            f_lv;
    logic [LEVEL_BITS-1:0] t_digit [4];
    logic [LEVEL_BITS-1:0] c_digit [4];
    logic [LVL_AW-1:0]     f_lvl_addr;

    always_comb
    begin
        t64 = {32'd0, exp_reg};
        c64 = {32'd0, tick_reg};
        f_near = ((t64 >> NEAR_BITS) == (c64 >> NEAR_BITS));
        for (int lv = 0; lv < 4; lv++)
        begin
            t_digit[lv] = LEVEL_BITS'(t64 >> (NEAR_BITS + lv * LEVEL_BITS));
            c_digit[lv] = LEVEL_BITS'(c64 >> (NEAR_BITS + lv * LEVEL_BITS));
        end
        for (int lv = 0; lv < 3; lv++)
        begin
            lv_match[lv] = ((t64 >> (NEAR_BITS + (lv + 1) * LEVEL_BITS)) ==
                            (c64 >> (NEAR_BITS + (lv + 1) * LEVEL_BITS)));
        end
        if (lv_match[0])
        begin
            f_lv = 2'd0;
        end
        else if (lv_match[1])
        begin
            f_lv = 2'd1;
        end
        else if (lv_match[2])
        begin
            f_lv = 2'd2;
        end
        else
        begin
            f_lv = 2'd3;
        end
        f_lvl_addr = {f_lv, t_digit[f_lv]};
    end

    // Cascade bucket due after the tick advanced
    logic              ref_need;
    logic              ref_done;
    logic [LVL_AW-1:0] ref_addr;

    always_comb
    begin
        ref_need = 1'b0;
        ref_done = 1'b0;
        ref_addr = '0;
        if (tick_reg == 32'd0)
        begin
            ref_need = 1'b1;
            ref_addr = {2'd3, {LEVEL_BITS{1'b0}}};
        end
        else
        begin
            for (int lv = 0; lv < 4; lv++)
            begin
                if (!ref_done)
                begin
                    if ((c64 & ((64'd1 << (NEAR_BITS + lv * LEVEL_BITS)) - 64'd1)) == 64'd0)
                    begin
                        if (c_digit[lv] != '0)
                        begin
                            ref_need = 1'b1;
                            ref_addr = {2'(lv), c_digit[lv]};
                            ref_done = 1'b1;
                        end
                    end
                    else
                    begin
                        ref_done = 1'b1;
                    end
                end
            end
        end
    end

    // Bucket word read back for an append or a clear
    htw_pkg::bucket_t b_old, b_new;
    logic             can_emit;
    logic             out_load;
    logic [CLR_W:0]   clr_succ;

    assign b_old    = bsel_near_reg ? near_rdata : lvl_rdata;
    assign can_emit = !out_valid_reg || !result_stall;
    assign clr_succ = {1'b0, clr_cnt_reg} + 1'b1;

    // Output register takes a new result this cycle
    assign out_load = (cmd.op == htw_pkg::OP_EMIT_ADD) || (cmd.op == htw_pkg::OP_FINISH) ||
                      ((cmd.op == htw_pkg::OP_DRAIN_WB) && pend_valid_reg);

    always_comb
    begin
        b_new.head = (b_old.head == htw_pkg::NIL) ? e_reg : b_old.head;
        b_new.tail = e_reg;
    end

    // Memory controls
    always_comb
    begin
        near_we = 1'b0; near_waddr = baddr_near_reg; near_wdata = b_new;
        near_re = 1'b0; near_raddr = tick_reg[NEAR_BITS-1:0];
        lvl_we  = 1'b0; lvl_waddr  = baddr_lvl_reg;  lvl_wdata  = b_new;
        lvl_re  = 1'b0; lvl_raddr  = ref_addr;
        nl_we   = 1'b0; nl_waddr   = e_reg[IDX_W-1:0]; nl_wdata = htw_pkg::NIL;
        ent_re  = 1'b0; ent_raddr  = cur_reg[IDX_W-1:0];
        ent_we  = 1'b0;
        case (cmd.op)
            htw_pkg::OP_ALLOC_RD:
            begin
                ent_re    = 1'b1;
                ent_raddr = free_head_reg[IDX_W-1:0];
            end
            htw_pkg::OP_ALLOC_WB:
            begin
                ent_we = 1'b1;
            end
            htw_pkg::OP_FILE_RD:
            begin
                nl_we      = 1'b1;
                near_re    = f_near;
                near_raddr = exp_reg[NEAR_BITS-1:0];
                lvl_re     = !f_near;
                lvl_raddr  = f_lvl_addr;
            end
            htw_pkg::OP_FILE_WB:
            begin
                near_we = bsel_near_reg;
                lvl_we  = !bsel_near_reg;
                if (b_old.head != htw_pkg::NIL && b_old.tail < POOL_P)
                begin
                    nl_we    = 1'b1;
                    nl_waddr = b_old.tail[IDX_W-1:0];
                    nl_wdata = e_reg;
                end
            end
            htw_pkg::OP_BKT_RD:
            begin
                near_re = cmd.near_sel;
                lvl_re  = !cmd.near_sel;
            end
            htw_pkg::OP_BKT_CLR:
            begin
                near_we    = bsel_near_reg;
                near_wdata = EMPTY;
                lvl_we     = !bsel_near_reg;
                lvl_wdata  = EMPTY;
            end
            htw_pkg::OP_ENT_RD:
            begin
                ent_re = 1'b1;
            end
            htw_pkg::OP_DRAIN_WB:
            begin
                nl_we    = 1'b1;
                nl_waddr = cur_reg[IDX_W-1:0];
                nl_wdata = free_head_reg;
            end
            htw_pkg::OP_CLEAR:
            begin
                near_we    = (clr_cnt_reg < CLR_W'(NEAR_SIZE));
                near_waddr = clr_cnt_reg[NEAR_BITS-1:0];
                near_wdata = EMPTY;
                lvl_we     = (clr_cnt_reg < CLR_W'(LVL_DEPTH));
                lvl_waddr  = clr_cnt_reg[LVL_AW-1:0];
                lvl_wdata  = EMPTY;
                nl_we      = (clr_cnt_reg < CLR_W'(POOL_ENTRIES));
                nl_waddr   = clr_cnt_reg[IDX_W-1:0];
                nl_wdata   = (clr_succ < (CLR_W + 1)'(POOL_ENTRIES)) ?
                             PW'(clr_succ) : htw_pkg::NIL;
            end
            default:
            begin
            end
        endcase
    end

    // Register updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg        <= '0;
            free_head_reg   <= '0;
            item_reg        <= '0;
            e_reg           <= '0;
            exp_reg         <= '0;
            cur_reg         <= htw_pkg::NIL;
            nxt_reg         <= htw_pkg::NIL;
            steps_reg       <= '0;
            bsel_near_reg   <= 1'b1;
            baddr_near_reg  <= '0;
            baddr_lvl_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            pend_handle_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && !result_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                htw_pkg::OP_CAPTURE:
                begin
                    item_reg <= item;
                end
                htw_pkg::OP_EMIT_ADD:
                begin
                    out_valid_reg     <= 1'b1;
                    out_reg.kind      <= cmd.kind;
                    out_reg.fired_handle <= (cmd.kind == htw_pkg::KIND_FIRED) ?
                                            item_reg.timer_handle : 32'd0;
                    out_reg.last      <= 1'b1;
                end
                htw_pkg::OP_ALLOC_RD:
                begin
                    e_reg <= free_head_reg;
                end
                htw_pkg::OP_ALLOC_WB:
                begin
                    free_head_reg <= nl_rdata;
                    exp_reg       <= add_expiry;
                end
                htw_pkg::OP_FILE_RD:
                begin
                    bsel_near_reg  <= f_near;
                    baddr_near_reg <= exp_reg[NEAR_BITS-1:0];
                    baddr_lvl_reg  <= f_lvl_addr;
                end
                htw_pkg::OP_FILE_WB:
                begin
                    cur_reg <= nxt_reg;
                end
                htw_pkg::OP_BKT_RD:
                begin
                    bsel_near_reg  <= cmd.near_sel;
                    baddr_near_reg <= tick_reg[NEAR_BITS-1:0];
                    baddr_lvl_reg  <= ref_addr;
                end
                htw_pkg::OP_BKT_CLR:
                begin
                    cur_reg   <= b_old.head;
                    steps_reg <= '0;
                end
                htw_pkg::OP_DRAIN_WB:
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.kind         <= htw_pkg::KIND_EXPIRED;
                        out_reg.fired_handle <= pend_handle_reg;
                        out_reg.last         <= 1'b0;
                    end
                    pend_valid_reg  <= 1'b1;
                    pend_handle_reg <= hdl_rdata;
                    free_head_reg   <= cur_reg;
                    cur_reg         <= nl_rdata;
                    steps_reg       <= steps_reg + 1'b1;
                end
                htw_pkg::OP_REFILE_GET:
                begin
                    nxt_reg   <= nl_rdata;
                    e_reg     <= cur_reg;
                    exp_reg   <= exp_rdata;
                    steps_reg <= steps_reg + 1'b1;
                end
                htw_pkg::OP_ADVANCE:
                begin
                    tick_reg <= tick_reg + 32'd1;
                end
                htw_pkg::OP_FINISH:
                begin
                    out_valid_reg        <= 1'b1;
                    out_reg.kind         <= pend_valid_reg ? htw_pkg::KIND_EXPIRED
                                                           : htw_pkg::KIND_NONE;
                    out_reg.fired_handle <= pend_valid_reg ? pend_handle_reg : 32'd0;
                    out_reg.last         <= 1'b1;
                    pend_valid_reg       <= 1'b0;
                end
                htw_pkg::OP_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Status to the controller
    assign status.mode        = item_reg.mode;
    assign status.fire_now    = (item_reg.delay_ticks == 32'sd0) || item_reg.delay_ticks[31];
    assign status.pool_empty  = (free_head_reg >= POOL_P);
    assign status.cur_ok      = (cur_reg < POOL_P) && (steps_reg < POOL_S);
    assign status.refile_need = ref_need;
    assign status.can_emit    = can_emit;
    assign status.pend_valid  = pend_valid_reg;
    assign status.clear_done  = (clr_cnt_reg == CLR_W'(CLR_DEPTH));

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== design/hierarchical_timing_wheel_unit.sv =====
// Top level of the hierarchical timing wheel: controller plus datapath.
// Depends on htw_pkg, htw_ctrl, htw_datapath (and htw_ram below it).
//
//   channel  | signals                        | moves
//   ---------+--------------------------------+-----------------------------
//   item     | item_valid, item_stall, item   | add or tick transaction in
//   result   | result_valid, result_stall,    | one result transaction out
//            | result                         |
//
// After reset a clearing pass over max(2^NEAR_BITS, 4*2^LEVEL_BITS, POOL_ENTRIES)
// addresses (256 by default) initializes the bucket and link memories; no item
// is taken meanwhile. An add that fires at once or is rejected goes straight to
// its result, one that is filed passes the allocate and file states first. A
// tick drains the expired entries of its near bucket, and a cascade re-files
// the entries of a level bucket through registered reads of the link memory.
// A stalled result holds the sequencer only when the next result is ready to
// be written into the output register.
`default_nettype none

module hierarchical_timing_wheel_unit #(
    parameter int POOL_ENTRIES = 64,
    parameter int NEAR_BITS    = 8,
    parameter int LEVEL_BITS   = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire htw_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output htw_pkg::result_t      result
);

    htw_pkg::cmd_t    cmd;
    htw_pkg::status_t status;

    htw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    htw_datapath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .NEAR_BITS    (NEAR_BITS),
        .LEVEL_BITS   (LEVEL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
